### hdl/assert_macros.svh
// Assertion macros used by the checker file.
// No dependencies; include by bare file name.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked check, masked while reset is low.
`define RSP_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) \
    else $error("rsp check failed");

// Clocked check that also holds during reset.
`define RSP_ASSERT_RST(lbl, prop) \
  lbl: assert property (@(posedge clk_i) prop) else $error("rsp reset check failed");

`endif

### hdl/rsp_pkg.sv
// Shared types, widths and codes of the resampling sample player.
// No dependencies.
package rsp_pkg;

  localparam int SAMPLE_DEPTH_DEF   = 65536;
  localparam int RATE_FRAC_BITS_DEF = 16;

  localparam int SAMPLE_W  = 16;
  localparam int RATE_W    = 20;
  localparam int POS_W     = 18;
  localparam int IDX_W     = 16;
  localparam int END_W     = 17;
  localparam int CFG_IDX_W = 3;
  localparam int CFG_W     = 20;

  localparam logic [1:0] ACT_LOAD  = 2'd0;
  localparam logic [1:0] ACT_START = 2'd1;
  localparam logic [1:0] ACT_NEXT  = 2'd2;

  localparam logic [CFG_IDX_W-1:0] CFG_START_INDEX = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_LOOP_START  = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_END_INDEX   = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_LOOP_MODE   = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_INTERP_MODE = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_RATE        = 3'd5;

  localparam logic [1:0] LOOP_REPEAT   = 2'd1;
  localparam logic [1:0] LOOP_PINGPONG = 2'd2;

  localparam logic signed [RATE_W-1:0] RATE_RESET = 20'sd65536;
  localparam logic signed [RATE_W-1:0] RATE_MIN   = 20'sh80000;
  localparam logic signed [RATE_W-1:0] RATE_MAX   = 20'sh7FFFF;

  typedef struct packed {
    logic [1:0]                 action;
    logic [IDX_W-1:0]           addr;
    logic signed [SAMPLE_W-1:0] data;
  } item_t;

  typedef struct packed {
    logic  valid;
    item_t item;
  } q_t;

endpackage

### hdl/rsp_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module rsp_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 256
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

### hdl/rsp_front.sv
// Front end: accepts command beats and holds them in a two-entry queue.
// Depends on rsp_pkg.
module rsp_front (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          start_i,
  input  rsp_pkg::item_t item_i,
  input  logic          pop_i,
  output logic          busy_o,
  output rsp_pkg::q_t   q_o
);
  import rsp_pkg::*;

  item_t      mem_q [2];
  logic       wr_ptr_q, wr_ptr_d;
  logic       rd_ptr_q, rd_ptr_d;
  logic [1:0] cnt_q, cnt_d;
  logic       push, pop;

  assign busy_o = cnt_q[1];
  assign push   = start_i && !busy_o;
  assign pop    = pop_i && (cnt_q != 2'd0);

  always_comb begin
    wr_ptr_d = push ? ~wr_ptr_q : wr_ptr_q;
    rd_ptr_d = pop ? ~rd_ptr_q : rd_ptr_q;
    cnt_d    = cnt_q;
    if (push && !pop) begin
      cnt_d = cnt_q + 2'd1;
    end else if (pop && !push) begin
      cnt_d = cnt_q - 2'd1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      cnt_q    <= 2'd0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      mem_q[wr_ptr_q] <= item_i;
    end
  end

  assign q_o.valid = (cnt_q != 2'd0);
  assign q_o.item  = mem_q[rd_ptr_q];

endmodule

### hdl/rsp_back.sv
// Back end: configuration, sample store, playback sequencer and interpolator.
// Depends on rsp_pkg and rsp_ram.
module rsp_back #(
  parameter int SAMPLE_DEPTH   = rsp_pkg::SAMPLE_DEPTH_DEF,
  parameter int RATE_FRAC_BITS = rsp_pkg::RATE_FRAC_BITS_DEF
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  rsp_pkg::q_t                         q_i,
  output logic                                pop_o,
  input  logic                                cfg_we_i,
  input  logic [rsp_pkg::CFG_IDX_W-1:0]       cfg_idx_i,
  input  logic [rsp_pkg::CFG_W-1:0]           cfg_wdata_i,
  output logic                                done_o,
  output logic signed [rsp_pkg::SAMPLE_W-1:0] sample_out_o,
  output logic                                sample_valid_o,
  output logic                                stopped_o
);
  import rsp_pkg::*;

  localparam int AW = $clog2(SAMPLE_DEPTH);
  localparam int RF = RATE_FRAC_BITS;
  localparam int FW = RF + 1;
  localparam int DW = ((FW > RATE_W) ? FW : RATE_W) + 1;
  localparam int XW = (AW > POS_W + 1) ? AW : POS_W + 1;
  localparam int PW = RF + SAMPLE_W + 1;
  localparam int NW = PW + 1;

  localparam logic signed [DW-1:0] ONE_D = {{(DW-1){1'b0}}, 1'b1} << RF;
  localparam logic [FW-1:0]        ONE_U = {{(FW-1){1'b0}}, 1'b1} << RF;
  localparam logic signed [NW-1:0] ONE_N = {{(NW-1){1'b0}}, 1'b1} << RF;

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_CHECK = 3'd1;
  localparam logic [2:0] S_RD0   = 3'd2;
  localparam logic [2:0] S_RD1   = 3'd3;
  localparam logic [2:0] S_MUL1  = 3'd4;
  localparam logic [2:0] S_MUL2  = 3'd5;
  localparam logic [2:0] S_OUT   = 3'd6;

  // configuration
  logic [IDX_W-1:0]         start_q, loop_start_q;
  logic [END_W-1:0]         end_q;
  logic [1:0]               mode_q;
  logic                     interp_q;
  logic signed [RATE_W-1:0] rate_cfg_q;

  // playback state
  logic [2:0]                 state_q, state_d;
  logic signed [POS_W-1:0]    pos_q, pos_d;
  logic signed [FW-1:0]       frac_q, frac_d;
  logic signed [RATE_W-1:0]   cur_rate_q, cur_rate_d;
  logic                       running_q, running_d;
  logic signed [SAMPLE_W-1:0] older_q, older_d, newer_q, newer_d;
  logic [1:0]                 filled_q, filled_d;
  logic                       retry_q, retry_d;

  // datapath holding registers
  logic signed [SAMPLE_W-1:0] cur_q, cur_d;
  logic [RF-1:0]              af_q, af_d;
  logic signed [PW-1:0]       p1_q, p1_d;
  logic signed [NW-1:0]       num_q, num_d;

  // result registers
  logic                       done_q, done_d;
  logic signed [SAMPLE_W-1:0] sample_q, sample_d;
  logic                       valid_q, valid_d;
  logic                       stopped_q, stopped_d;

  // store
  logic                ram_we;
  logic [AW-1:0]       ram_raddr;
  logic [SAMPLE_W-1:0] ram_rdata_raw;
  logic signed [SAMPLE_W-1:0] ram_rdata;

  rsp_ram #(
    .WIDTH (SAMPLE_W),
    .DEPTH (SAMPLE_DEPTH)
  ) u_store (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (AW'(q_i.item.addr)),
    .wdata_i (q_i.item.data),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata_raw)
  );
  assign ram_rdata = $signed(ram_rdata_raw);

  // bounds and jump targets
  logic                    fwd, oob;
  logic signed [POS_W:0]   pos_x, end_x, start_x;
  logic signed [POS_W-1:0] end_m1, pos_jump;
  logic signed [RATE_W-1:0] rate_neg;

  assign fwd     = !cur_rate_q[RATE_W-1];
  assign pos_x   = (POS_W+1)'(pos_q);
  assign end_x   = $signed({2'b00, end_q});
  assign start_x = $signed({3'b000, start_q});
  assign oob     = fwd ? (pos_x >= end_x) : (pos_x < start_x);
  assign end_m1  = $signed({1'b0, end_q} - 18'd1);
  assign rate_neg = (cur_rate_q == RATE_MIN) ? RATE_MAX : -cur_rate_q;

  always_comb begin
    if (mode_q == LOOP_PINGPONG) begin
      pos_jump = fwd ? end_m1 : $signed(POS_W'(start_q));
    end else begin
      pos_jump = fwd ? $signed(POS_W'(loop_start_q)) : end_m1;
    end
  end

  // store addresses: current position and its neighbor behind the motion
  logic signed [XW-1:0] pos_e, nb_e;
  logic [AW-1:0]        pos_addr, nb_addr;

  assign pos_e    = XW'(pos_q);
  assign nb_e     = pos_e + $signed({{(XW-1){~cur_rate_q[RATE_W-1]}}, 1'b1});
  assign pos_addr = pos_e[AW-1:0];
  assign nb_addr  = nb_e[AW-1:0];

  // fraction, step and crossing
  logic signed [DW-1:0] frac_x, rate_x, diff, rsum, radj, rq, rrem;
  logic [FW-1:0]        af_full;
  logic [RF-1:0]        af;
  logic                 cross_f, cross_r, big;

  assign frac_x  = DW'(frac_q);
  assign rate_x  = DW'(cur_rate_q);
  assign af_full = frac_q[FW-1] ? FW'(-frac_q) : FW'(frac_q);
  assign af      = af_full[RF-1:0];
  assign diff    = frac_x - rate_x;
  assign cross_f = (rate_x > 0) && diff[DW-1];
  assign cross_r = rate_x[DW-1] && (diff > 0);
  assign big     = cross_f ? (rate_x > ONE_D) : (rate_x < -ONE_D);
  assign rsum    = frac_x + rate_x;
  // truncate toward zero: bias negative sums before the shift
  assign radj    = rsum[DW-1] ? (rsum + ONE_D - DW'(1)) : rsum;
  assign rq      = radj >>> RF;
  assign rrem    = rsum - (rq <<< RF);

  // point update for the interpolator
  logic signed [SAMPLE_W-1:0] pt_older, pt_newer, pt_res, pt_base;
  logic [1:0]                 pt_filled, filled_inc;
  logic                       pt_mul;

  assign filled_inc = filled_q[1] ? filled_q : filled_q + 2'd1;
  assign pt_base    = big ? ram_rdata : newer_q;

  always_comb begin
    pt_older  = older_q;
    pt_newer  = newer_q;
    pt_filled = filled_q;
    pt_res    = cur_q;
    pt_mul    = 1'b0;
    if (interp_q) begin
      if (af != '0) begin
        if (cross_f || cross_r) begin
          pt_older  = pt_base;
          pt_newer  = cur_q;
          pt_filled = filled_inc;
        end
        pt_mul = pt_filled[1];
      end else begin
        pt_older  = newer_q;
        pt_newer  = cur_q;
        pt_filled = filled_inc;
        pt_res    = newer_q;
      end
    end
  end

  // interpolation products and rounding toward zero
  logic signed [NW-1:0] p2, nadj, nres;

  assign p1_d = PW'($signed({1'b0, af_q})) * PW'(newer_q);
  assign p2   = NW'($signed({1'b0, ONE_U - {1'b0, af_q}})) * NW'(older_q);
  assign nadj = num_q[NW-1] ? (num_q + ONE_N - NW'(1)) : num_q;
  assign nres = nadj >>> RF;

  always_comb begin
    state_d    = state_q;
    pos_d      = pos_q;
    frac_d     = frac_q;
    cur_rate_d = cur_rate_q;
    running_d  = running_q;
    older_d    = older_q;
    newer_d    = newer_q;
    filled_d   = filled_q;
    retry_d    = retry_q;
    cur_d      = cur_q;
    af_d       = af_q;
    num_d      = num_q;
    done_d     = 1'b0;
    sample_d   = sample_q;
    valid_d    = valid_q;
    stopped_d  = stopped_q;
    pop_o      = 1'b0;
    ram_we     = 1'b0;
    ram_raddr  = pos_addr;
    case (state_q)
      S_IDLE: begin
        if (q_i.valid) begin
          pop_o     = 1'b1;
          done_d    = 1'b1;
          sample_d  = '0;
          valid_d   = 1'b0;
          stopped_d = !running_q;
          case (q_i.item.action)
            ACT_LOAD: begin
              ram_we = 1'b1;
            end
            ACT_START: begin
              cur_rate_d = rate_cfg_q;
              pos_d      = (rate_cfg_q > 20'sd0) ? $signed(POS_W'(start_q)) : end_m1;
              frac_d     = '0;
              older_d    = '0;
              newer_d    = '0;
              filled_d   = 2'd0;
              running_d  = 1'b1;
              stopped_d  = 1'b0;
            end
            ACT_NEXT: begin
              if (running_q) begin
                done_d  = 1'b0;
                retry_d = 1'b0;
                state_d = S_CHECK;
              end
            end
            default: ;
          endcase
        end
      end
      S_CHECK: begin
        if (oob) begin
          if (!retry_q && (mode_q == LOOP_REPEAT || mode_q == LOOP_PINGPONG)) begin
            retry_d = 1'b1;
            pos_d   = pos_jump;
            if (mode_q == LOOP_PINGPONG) begin
              cur_rate_d = rate_neg;
            end
          end else begin
            running_d = 1'b0;
            done_d    = 1'b1;
            sample_d  = '0;
            valid_d   = 1'b0;
            stopped_d = 1'b1;
            state_d   = S_IDLE;
          end
        end else begin
          state_d = S_RD0;
        end
      end
      S_RD0: begin
        // current sample lands; fetch the neighbor
        ram_raddr = nb_addr;
        cur_d     = ram_rdata;
        state_d   = S_RD1;
      end
      S_RD1: begin
        older_d  = pt_older;
        newer_d  = pt_newer;
        filled_d = pt_filled;
        af_d     = af;
        frac_d   = FW'(rrem);
        pos_d    = pos_q + POS_W'(rq);
        if (pt_mul) begin
          state_d = S_MUL1;
        end else begin
          done_d    = 1'b1;
          sample_d  = pt_res;
          valid_d   = 1'b1;
          stopped_d = 1'b0;
          state_d   = S_IDLE;
        end
      end
      S_MUL1: begin
        state_d = S_MUL2;
      end
      S_MUL2: begin
        num_d   = NW'(p1_q) + p2;
        state_d = S_OUT;
      end
      S_OUT: begin
        done_d    = 1'b1;
        sample_d  = nres[SAMPLE_W-1:0];
        valid_d   = 1'b1;
        stopped_d = 1'b0;
        state_d   = S_IDLE;
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      start_q      <= '0;
      loop_start_q <= '0;
      end_q        <= '0;
      mode_q       <= '0;
      interp_q     <= 1'b0;
      rate_cfg_q   <= RATE_RESET;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_START_INDEX: start_q      <= cfg_wdata_i[IDX_W-1:0];
        CFG_LOOP_START:  loop_start_q <= cfg_wdata_i[IDX_W-1:0];
        CFG_END_INDEX:   end_q        <= cfg_wdata_i[END_W-1:0];
        CFG_LOOP_MODE:   mode_q       <= cfg_wdata_i[1:0];
        CFG_INTERP_MODE: interp_q     <= cfg_wdata_i[0];
        CFG_RATE:        rate_cfg_q   <= $signed(cfg_wdata_i[RATE_W-1:0]);
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= S_IDLE;
      pos_q      <= '0;
      frac_q     <= '0;
      cur_rate_q <= '0;
      running_q  <= 1'b0;
      older_q    <= '0;
      newer_q    <= '0;
      filled_q   <= 2'd0;
      retry_q    <= 1'b0;
      done_q     <= 1'b0;
      valid_q    <= 1'b0;
      stopped_q  <= 1'b1;
    end else begin
      state_q    <= state_d;
      pos_q      <= pos_d;
      frac_q     <= frac_d;
      cur_rate_q <= cur_rate_d;
      running_q  <= running_d;
      older_q    <= older_d;
      newer_q    <= newer_d;
      filled_q   <= filled_d;
      retry_q    <= retry_d;
      done_q     <= done_d;
      valid_q    <= valid_d;
      stopped_q  <= stopped_d;
    end
  end

  always_ff @(posedge clk_i) begin
    cur_q    <= cur_d;
    af_q     <= af_d;
    p1_q     <= p1_d;
    num_q    <= num_d;
    sample_q <= sample_d;
  end

  assign done_o         = done_q;
  assign sample_out_o   = sample_q;
  assign sample_valid_o = valid_q;
  assign stopped_o      = stopped_q;

endmodule

### hdl/resampling_sample_player_core.sv
// Top level of the resampling sample player: command queue plus playback back end.
// Depends on rsp_pkg, rsp_front and rsp_back.
//
// channel   direction  handshake              payload
// command   in         start_i & !busy_o      action_i, load_address_i, load_data_i
// result    out        done_o (one cycle)     sample_out_o, sample_valid_o, stopped_o
// config    in         cfg_we_i               cfg_idx_i, cfg_wdata_i
//
// A command is visible to the back end in the cycle after it is taken; its result follows.
// Load, start and idle next beats are answered straight from idle; a playing next beat
// checks the bound, with one loop jump and a second check at most, and either stops at
// the bound or reads the current sample and then its neighbor on the single read port,
// followed by the two-step multiply when it blends two points.
// busy_o rises when the two-entry queue is full. Reset is asynchronous, active low;
// the store holds no reset. Results cannot be stalled.
module resampling_sample_player_core #(
  parameter int SAMPLE_DEPTH   = rsp_pkg::SAMPLE_DEPTH_DEF,
  parameter int RATE_FRAC_BITS = rsp_pkg::RATE_FRAC_BITS_DEF
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                start_i,
  output logic                                busy_o,
  input  logic [1:0]                          action_i,
  input  logic [rsp_pkg::IDX_W-1:0]           load_address_i,
  input  logic signed [rsp_pkg::SAMPLE_W-1:0] load_data_i,
  input  logic                                cfg_we_i,
  input  logic [rsp_pkg::CFG_IDX_W-1:0]       cfg_idx_i,
  input  logic [rsp_pkg::CFG_W-1:0]           cfg_wdata_i,
  output logic                                done_o,
  output logic signed [rsp_pkg::SAMPLE_W-1:0] sample_out_o,
  output logic                                sample_valid_o,
  output logic                                stopped_o
);
  import rsp_pkg::*;

  item_t item;
  q_t    q;
  logic  pop;

  assign item.action = action_i;
  assign item.addr   = load_address_i;
  assign item.data   = load_data_i;

  rsp_front u_front (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start_i(start_i),
    .item_i (item),
    .pop_i  (pop),
    .busy_o (busy_o),
    .q_o    (q)
  );

  rsp_back #(
    .SAMPLE_DEPTH   (SAMPLE_DEPTH),
    .RATE_FRAC_BITS (RATE_FRAC_BITS)
  ) u_back (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .q_i            (q),
    .pop_o          (pop),
    .cfg_we_i       (cfg_we_i),
    .cfg_idx_i      (cfg_idx_i),
    .cfg_wdata_i    (cfg_wdata_i),
    .done_o         (done_o),
    .sample_out_o   (sample_out_o),
    .sample_valid_o (sample_valid_o),
    .stopped_o      (stopped_o)
  );

endmodule

### hdl/rsp_checker.sv
// Port-level checks of the sample player result channel, bound to the top level.
// Depends on assert_macros.svh and rsp_pkg.
`include "assert_macros.svh"

module rsp_checker (
  input logic                                clk_i,
  input logic                                rst_ni,
  input logic                                done_o,
  input logic signed [rsp_pkg::SAMPLE_W-1:0] sample_out_o,
  input logic                                sample_valid_o,
  input logic                                stopped_o
);

  // no result beat while reset is held
  `RSP_ASSERT_RST(a_no_done_in_reset, !rst_ni |-> (done_o !== 1'b1))
  // a beat without a sample carries zero
  `RSP_ASSERT(a_idle_zero, done_o && !sample_valid_o |-> sample_out_o == '0)
  // a produced sample means playback goes on
  `RSP_ASSERT(a_valid_running, done_o && sample_valid_o |-> !stopped_o)

endmodule

bind resampling_sample_player_core rsp_checker u_rsp_checker (.*);
